// ===== sv/rau_pkg.sv =====
// Package for the rational arithmetic unit: word types, opcodes, status codes,
// controller states and the command and status bundles between control and datapath.
// Depends on nothing.
`default_nettype none
package rau_pkg;
	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] res_num;
		logic [30:0]        res_den;
		logic [1:0]         status;
	} out_word_t;

	localparam logic [2:0] KIND_ADD = 3'd0;
	localparam logic [2:0] KIND_SUB = 3'd1;
	localparam logic [2:0] KIND_MUL = 3'd2;
	localparam logic [2:0] KIND_DIV = 3'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_DEN = 2'd1;
	localparam logic [1:0] ST_OVERFLOW = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_NUM,
		S_MUL_CROSS,
		S_ADD,
		S_MUL_DEN,
		S_CHECK,
		S_GCD,
		S_GCD_FIN,
		S_DIV_N,
		S_DIV_SW,
		S_DIV_D,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic mul_num;
		logic mul_cross;
		logic add_cross;
		logic mul_den;
		logic check;
		logic gcd_step;
		logic gcd_fin;
		logic div_ld_d;
		logic div_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic is_addsub;
		logic den_zero;
		logic num_zero;
		logic gcd_done;
		logic div_last;
	} sts_t;
endpackage
`default_nettype wire

// ===== sv/rau_ctrl.sv =====
// Controller state machine of the rational arithmetic unit.
// Depends on rau_pkg; drives the datapath rau_dp through cmd_t and reads sts_t.
`default_nettype none
module rau_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  wire logic          out_stall,
	output rau_pkg::cmd_t      cmd,
	input  wire rau_pkg::sts_t sts
);
	import rau_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE:      if (in_valid) state_nxt = S_MUL_NUM;
			S_MUL_NUM:   state_nxt = sts.is_addsub ? S_MUL_CROSS : S_MUL_DEN;
			S_MUL_CROSS: state_nxt = S_ADD;
			S_ADD:       state_nxt = S_MUL_DEN;
			S_MUL_DEN:   state_nxt = S_CHECK;
			S_CHECK:     state_nxt = (sts.den_zero || sts.num_zero) ? S_DONE : S_GCD;
			S_GCD:       if (sts.gcd_done) state_nxt = S_GCD_FIN;
			S_GCD_FIN:   state_nxt = S_DIV_N;
			S_DIV_N:     if (sts.div_last) state_nxt = S_DIV_SW;
			S_DIV_SW:    state_nxt = S_DIV_D;
			S_DIV_D:     if (sts.div_last) state_nxt = S_DONE;
			S_DONE:      if (!out_valid_q || !out_stall) state_nxt = S_IDLE;
			default:     state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE:      cmd.load = in_valid;
			S_MUL_NUM:   cmd.mul_num = 1'b1;
			S_MUL_CROSS: cmd.mul_cross = 1'b1;
			S_ADD:       cmd.add_cross = 1'b1;
			S_MUL_DEN:   cmd.mul_den = 1'b1;
			S_CHECK:     cmd.check = 1'b1;
			S_GCD:       cmd.gcd_step = 1'b1;
			S_GCD_FIN:   cmd.gcd_fin = 1'b1;
			S_DIV_N:     cmd.div_step = 1'b1;
			S_DIV_SW:    cmd.div_ld_d = 1'b1;
			S_DIV_D:     cmd.div_step = 1'b1;
			S_DONE:      cmd.out_load = !out_valid_q || !out_stall;
			default:     cmd = '0;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// ===== sv/rau_dp.sv =====
// Datapath of the rational arithmetic unit: shared multiplier, binary GCD unit,
// restoring divider and the result register. Depends on rau_pkg.
`default_nettype none
module rau_dp #(
	parameter int OPERAND_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire rau_pkg::in_word_t in_word,
	input  wire rau_pkg::cmd_t     cmd,
	output rau_pkg::sts_t          sts,
	output rau_pkg::out_word_t     out_word
);
	import rau_pkg::*;

	localparam int W  = OPERAND_WIDTH;
	localparam int DW = 2 * W;
	localparam int KW = $clog2(DW);

	logic [2:0]           kind_q;
	logic signed [W:0]    an_q, ad_q, bn_q, bd_q;
	logic signed [DW:0]   num_q, den_q, cross_q;
	logic signed [W:0]    ma, mb;
	logic signed [DW+1:0] prod;
	logic [DW:0]          num_abs, den_abs;
	logic [DW-1:0]        x_q, y_q, n0_q, d0_q, g_q, rem_q, dq_q, nq_q;
	logic [KW-1:0]        k_q, cnt_q;
	logic                 neg_q, den_zero_q, num_zero_q;
	logic [DW:0]          trial, diff;
	logic                 ge;
	logic [63:0]          nm64, rn64, dm64;
	logic                 ovf;
	logic                 is_norm;

	assign is_norm = (kind_q != KIND_ADD) && (kind_q != KIND_SUB)
		&& (kind_q != KIND_MUL) && (kind_q != KIND_DIV);

	always_comb begin
		ma = an_q;
		mb = (W+1)'(1);
		if (cmd.mul_cross) begin
			ma = bn_q;
			mb = ad_q;
		end else if (cmd.mul_den) begin
			ma = ad_q;
			if (kind_q == KIND_DIV) begin
				mb = bn_q;
			end else if (!is_norm) begin
				mb = bd_q;
			end
		end else begin
			if (kind_q == KIND_MUL) begin
				mb = bn_q;
			end else if (!is_norm) begin
				mb = bd_q;
			end
		end
	end

	assign prod    = ma * mb;
	assign num_abs = num_q[DW] ? -num_q : num_q;
	assign den_abs = den_q[DW] ? -den_q : den_q;
	assign trial   = {rem_q, dq_q[DW-1]};
	assign diff    = trial - {1'b0, g_q};
	assign ge      = !diff[DW];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_word.kind;
			an_q   <= (W+1)'(signed'(in_word.a_num[W-1:0]));
			ad_q   <= (W+1)'(signed'(in_word.a_den[W-1:0]));
			bn_q   <= (W+1)'(signed'(in_word.b_num[W-1:0]));
			bd_q   <= signed'({2'b00, in_word.b_den[W-2:0]});
		end
		if (cmd.mul_num) begin
			num_q <= prod[DW:0];
		end
		if (cmd.mul_cross) begin
			cross_q <= prod[DW:0];
		end
		if (cmd.add_cross) begin
			num_q <= (kind_q == KIND_SUB) ? num_q - cross_q : num_q + cross_q;
		end
		if (cmd.mul_den) begin
			den_q <= prod[DW:0];
		end
		if (cmd.check) begin
			neg_q      <= num_q[DW] ^ den_q[DW];
			den_zero_q <= (den_q == '0);
			num_zero_q <= (num_q == '0);
			x_q        <= num_abs[DW-1:0];
			y_q        <= den_abs[DW-1:0];
			n0_q       <= num_abs[DW-1:0];
			d0_q       <= den_abs[DW-1:0];
			k_q        <= '0;
		end
		if (cmd.gcd_step && (x_q != y_q)) begin
			if (!x_q[0] && !y_q[0]) begin
				x_q <= x_q >> 1;
				y_q <= y_q >> 1;
				k_q <= k_q + KW'(1);
			end else if (!x_q[0]) begin
				x_q <= x_q >> 1;
			end else if (!y_q[0]) begin
				y_q <= y_q >> 1;
			end else if (x_q > y_q) begin
				x_q <= x_q - y_q;
			end else begin
				y_q <= y_q - x_q;
			end
		end
		if (cmd.gcd_fin) begin
			g_q   <= x_q << k_q;
			dq_q  <= n0_q;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_ld_d) begin
			nq_q  <= dq_q;
			dq_q  <= d0_q;
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			dq_q  <= {dq_q[DW-2:0], ge};
			cnt_q <= cnt_q + KW'(1);
		end
		if (cmd.out_load) begin
			if (den_zero_q) begin
				out_word.res_num <= '0;
				out_word.res_den <= 31'd1;
				out_word.status  <= ST_ZERO_DEN;
			end else if (num_zero_q) begin
				out_word.res_num <= '0;
				out_word.res_den <= 31'd1;
				out_word.status  <= ST_OK;
			end else begin
				out_word.res_num <= signed'(rn64[31:0]);
				out_word.res_den <= dm64[30:0];
				out_word.status  <= ovf ? ST_OVERFLOW : ST_OK;
			end
		end
	end

	assign nm64 = 64'(nq_q);
	assign dm64 = 64'(dq_q);
	assign rn64 = neg_q ? -nm64 : nm64;
	assign ovf  = (|nq_q[DW-1:W-1]) || (|dq_q[DW-1:W-1]);

	assign sts.is_addsub = (kind_q == KIND_ADD) || (kind_q == KIND_SUB);
	assign sts.den_zero  = (den_q == '0);
	assign sts.num_zero  = (num_q == '0);
	assign sts.gcd_done  = (x_q == y_q);
	assign sts.div_last  = (cnt_q == KW'(DW - 1));
endmodule
`default_nettype wire

// ===== sv/rational_arithmetic_unit_top.sv =====
// Top level of the rational arithmetic unit; joins the controller rau_ctrl and
// the datapath rau_dp. Depends on rau_pkg.
//
// The unit takes one word at a time and returns one result word for it. Each word
// passes the multiply states (the cross product and add only for add and subtract),
// the binary GCD steps and the two restoring divisions by the GCD; a zero numerator
// or denominator skips the GCD and both divisions. The next word is taken while the
// previous result still waits in the output register.
`default_nettype none
module rational_arithmetic_unit_top #(
	parameter int OPERAND_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rau_pkg::in_word_t in_word,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output rau_pkg::out_word_t     out_word
);
	import rau_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rau_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	rau_dp #(
		.OPERAND_WIDTH (OPERAND_WIDTH)
	) u_dp (
		.clk      (clk),
		.in_word  (in_word),
		.cmd      (cmd),
		.sts      (sts),
		.out_word (out_word)
	);
endmodule
`default_nettype wire

// ===== sv/rau_checker.sv =====
// Port-level assertions for the rational arithmetic unit and the bind that
// attaches them to rational_arithmetic_unit_top. Depends on rau_pkg.
`default_nettype none
module rau_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire rau_pkg::out_word_t out_word
);
	import rau_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("Stalled result word changed or dropped.");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("Unit took no busy state after accepting a word.");

	a_zero_den_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == ST_ZERO_DEN |->
			out_word.res_num == 32'sd0 && out_word.res_den == 31'd1)
		else $error("Zero denominator result is not 0/1.");

	a_zero_num_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.status == ST_OK && out_word.res_num == 32'sd0 |->
			out_word.res_den == 31'd1)
		else $error("Zero numerator result has a denominator other than 1.");
endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);
`default_nettype wire

// ===== verif/rau_checker.sv =====
// Checker for the rational arithmetic unit: watches both channels, predicts each
// result word from the accepted input word and compares. Depends on rau_pkg.
`default_nettype none
module tb_rau_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire rau_pkg::in_word_t in_word,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire rau_pkg::out_word_t out_word,
	output int                     errors,
	output int                     pending
);
	import rau_pkg::*;

	out_word_t fraction_q[$];

	function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic out_word_t reduce_fraction(in_word_t w);
		out_word_t r;
		longint an, ad, bn, bd, num, den;
		longint unsigned nm, dm, g, rn;
		logic neg;
		an = longint'(w.a_num);
		ad = longint'(w.a_den);
		bn = longint'(w.b_num);
		bd = longint'({1'b0, w.b_den});
		case (w.kind)
			KIND_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
			KIND_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
			KIND_MUL: begin num = an * bn; den = ad * bd; end
			KIND_DIV: begin num = an * bd; den = ad * bn; end
			default: begin num = an; den = ad; end
		endcase
		if (den == 0) begin
			r.res_num = 0; r.res_den = 1; r.status = ST_ZERO_DEN;
		end else if (num == 0) begin
			r.res_num = 0; r.res_den = 1; r.status = ST_OK;
		end else begin
			nm = (num < 0) ? -num : num;
			dm = (den < 0) ? -den : den;
			g = euclid_gcd(nm, dm);
			nm = nm / g;
			dm = dm / g;
			neg = (num < 0) != (den < 0);
			r.status = (nm > 64'h7FFFFFFF || dm > 64'h7FFFFFFF) ? ST_OVERFLOW : ST_OK;
			rn = neg ? -nm : nm;
			r.res_num = rn[31:0];
			r.res_den = dm[30:0];
		end
		return r;
	endfunction

	assign pending = fraction_q.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t e;
		if (!arst_n) begin
			errors <= 0;
		end else begin
			if (in_valid && !in_stall)
				fraction_q.push_back(reduce_fraction(in_word));
			if (out_valid && !out_stall) begin
				if (fraction_q.size() == 0) begin
					$display("%0t: unexpected result word %h", $time, out_word);
					errors <= errors + 1;
				end else begin
					e = fraction_q.pop_front();
					if (e.res_num !== out_word.res_num || e.res_den !== out_word.res_den
						|| e.status !== out_word.status) begin
						$display("%0t: expected %0d/%0d st %0d, got %0d/%0d st %0d", $time,
							e.res_num, e.res_den, e.status, out_word.res_num,
							out_word.res_den, out_word.status);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== verif/tb_rational_arithmetic_unit_top.sv =====
// Testbench top for the rational arithmetic unit: drives directed and random
// words under several idling phases and gives the verdict. Depends on rau_pkg,
// tb_rau_checker and rational_arithmetic_unit_top.
`default_nettype none
module tb_rational_arithmetic_unit_top;
	import rau_pkg::*;

	logic clk = 0, arst_n = 0, in_valid = 0, out_stall = 0;
	logic in_stall, out_valid;
	in_word_t in_word = '0;
	out_word_t out_word;
	int errors, pending, send_idle = 0, recv_idle = 0, cycles = 0;
	bit hold_off = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	rational_arithmetic_unit_top dut (.clk, .arst_n, .in_valid, .in_stall, .in_word,
		.out_valid, .out_stall, .out_word);

	tb_rau_checker chk (.clk, .arst_n, .in_valid, .in_stall, .in_word, .out_valid,
		.out_stall, .out_word, .errors, .pending);

	always @(negedge clk)
		out_stall <= hold_off || ($urandom_range(99) < recv_idle);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 3000000) begin
			$display("status: fail");
			$finish;
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(7))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000001;
			2: return 0;
			3: return $urandom_range(1, 2);
			4: return -$urandom_range(1, 20);
			5: return $urandom_range(1, 1000);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(logic [2:0] k, logic [31:0] an, logic [31:0] ad,
		logic [31:0] bn, logic [30:0] bd);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		in_valid = 1;
		in_word = '{kind: k, a_num: an, a_den: ad, b_num: bn, b_den: bd};
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic send_random();
		logic [31:0] ad;
		logic [30:0] bd;
		ad = pick_value();
		bd = 31'(pick_value());
		if ($urandom_range(9) != 0) begin
			if (ad == 0) ad = 1;
			if (bd == 0) bd = 1;
		end
		send_word(3'($urandom_range(7)), pick_value(), ad, pick_value(), bd);
	endtask

	task automatic drain();
		while (pending != 0) @(negedge clk);
		repeat (500) @(negedge clk);
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);
		send_word(KIND_ADD, 1, 2, 1, 3);
		send_word(KIND_SUB, 1, 2, 1, 2);
		send_word(KIND_MUL, 32'h7FFFFFFF, 1, 32'h7FFFFFFF, 1);
		send_word(KIND_DIV, 3, 4, 0, 5);
		send_word(KIND_DIV, 32'h80000001, 1, 1, 31'h7FFFFFFF);
		send_word(3'd4, 6, -4, 0, 0);
		send_word(3'd4, 5, 0, 1, 1);
		send_word(KIND_ADD, 1, 0, 1, 1);
		send_word(KIND_ADD, 1, 1, 1, 0);
		send_word(3'd5, 0, -7, 1, 1);
		send_word(3'd6, -9, 12, 1, 1);
		send_word(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1, 1);
		send_word(KIND_ADD, 32'h7FFFFFFF, 32'h7FFFFFFE, 32'h7FFFFFFF, 31'h7FFFFFFD);
		send_word(KIND_SUB, 32'h80000001, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFE);
		send_word(KIND_MUL, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hAAAAAAAA, 31'h55555555);
		send_word(KIND_MUL, 32'h55555555, 32'h80000000, 32'h80000000, 31'h2AAAAAAA);
		send_word(KIND_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 1);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 84 : 10) : 0;
			recv_idle = (ph == 2) ? 84 : (ph == 3 ? 10 : 0);
			if (ph == 0) begin
				fork
					begin hold_off = 1; repeat (2000) @(negedge clk); hold_off = 0; end
					repeat (6) send_random();
				join
			end
			repeat (455) send_random();
			drain();
		end
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire
